@@ rtl/core/hnts_pkg.sv @@
package hnts_pkg;

    // Default depth of the held-note stack.
    localparam int HELD_DEPTH = 16;

    // Field widths fixed by the event format.
    localparam int NOTE_W   = 7;
    localparam int OP_W     = 2;
    localparam int ACTION_W = 3;
    localparam int XPOSE_W  = 8;
    localparam int COUNT_W  = 5;

    // Velocity above this value marks a direct-mode note as accented.
    localparam logic [NOTE_W-1:0] ACCENT_THRESHOLD = 7'd100;

    // Reset value of the root note.
    localparam logic [NOTE_W-1:0] ROOT_RESET = 7'd36;

    // Event kinds.
    localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [OP_W-1:0] OP_ALL_OFF  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

    // Result actions.
    localparam logic [ACTION_W-1:0] ACT_VOICE_ON        = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_VOICE_OFF       = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_TRANSPOSE       = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_TRANSPOSE_START = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_STOP            = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_PATTERN_MODE = 1'b0;
    localparam logic CFG_ROOT_NOTE    = 1'b1;

    // One input event.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] velocity;
    } in_item_t;

    // One result.
    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [XPOSE_W-1:0] transpose;
        logic [NOTE_W-1:0]         voice_note;
        logic                      accent;
        logic [COUNT_W-1:0]        held_count;
    } out_item_t;

endpackage

@@ rtl/core/held_note_transpose_stack_core.sv @@
// Note-on, all-notes-off, direct-mode events and unmatched-free paths: the item is
// accepted, executed in the EXEC state, staged in a result register and moved to
// the output register in the EMIT state once the output is free. Pattern-mode
// note-off: a pipelined scan of the held stack, a compaction walk and a top-of-stack read.
// One item is in work at a time; the stack memory's single read port sets the pace.
// Synchronous active-low reset clears the note count, mode (direct) and root note (36).
module held_note_transpose_stack_core
    import hnts_pkg::*;
#(
    parameter int MAX_HELD = HELD_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [NOTE_W-1:0] cfg_wdata
);

    localparam int AW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
    localparam int CW = $clog2(MAX_HELD + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_TOPRD  = 3'd4;
    localparam logic [2:0] ST_TOPRES = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     total_reg, total_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              vld_reg, vld_next;
    logic              mode_reg;
    logic [NOTE_W-1:0] root_reg;
    logic [OP_W-1:0]   op_reg;
    logic [NOTE_W-1:0] note_reg;
    logic [NOTE_W-1:0] vel_reg;
    out_item_t         res_reg, res_next;
    out_item_t         m_data_reg;
    out_item_t         m_load_data;
    logic              m_valid_reg;
    logic              m_load;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [NOTE_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [NOTE_W-1:0] rd_data;

    logic [NOTE_W-1:0]         alu_a, alu_b;
    logic signed [XPOSE_W-1:0] alu_diff;
    logic                      alu_eq;

    logic [CW-1:0] total_dec;
    logic [CW-1:0] ptr_inc;
    logic [CW-1:0] idx_inc;
    logic          s_accept;

    assign total_dec = total_reg - 1'b1;
    assign ptr_inc   = ptr_reg + 1'b1;
    assign idx_inc   = idx_reg + 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    hnts_mem #(
        .DEPTH (MAX_HELD),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    hnts_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .eq   (alu_eq)
    );

    // Sequencer: dispatch, scan, compaction and top-of-stack read.
    always_comb begin
        state_next = state_reg;
        total_next = total_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        vld_next   = 1'b0;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg[AW-1:0];
        mem_wdata  = rd_data;
        mem_raddr  = '0;
        alu_a      = note_reg;
        alu_b      = root_reg;
        m_load     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_data.op != OP_UNUSED)) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_next   = '0;
                state_next = ST_EMIT;
                case (op_reg)
                    OP_NOTE_ON: begin
                        if (!mode_reg) begin
                            res_next.action     = ACT_VOICE_ON;
                            res_next.voice_note = note_reg;
                            res_next.accent     = (vel_reg > ACCENT_THRESHOLD);
                        end else begin
                            res_next.action    = (total_reg == '0) ? ACT_TRANSPOSE_START
                                                                   : ACT_TRANSPOSE;
                            res_next.transpose = alu_diff;
                            if (total_reg < CW'(MAX_HELD)) begin
                                mem_we     = 1'b1;
                                mem_waddr  = total_reg[AW-1:0];
                                mem_wdata  = note_reg;
                                total_next = total_reg + 1'b1;
                            end
                        end
                    end
                    OP_NOTE_OFF: begin
                        if (!mode_reg) begin
                            res_next.action = ACT_VOICE_OFF;
                        end else if (total_reg == '0) begin
                            res_next.action = ACT_STOP;
                        end else begin
                            ptr_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    OP_ALL_OFF: begin
                        total_next      = '0;
                        res_next.action = mode_reg ? ACT_STOP : ACT_VOICE_OFF;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN: begin
                // Issue the next read while the previous entry is compared.
                alu_a = rd_data;
                alu_b = note_reg;
                if (ptr_reg < total_reg) begin
                    mem_raddr = ptr_reg[AW-1:0];
                    vld_next  = 1'b1;
                    idx_next  = ptr_reg;
                    ptr_next  = ptr_inc;
                end
                if (vld_reg) begin
                    if (alu_eq) begin
                        total_next = total_dec;
                        idx_next   = idx_reg;
                        vld_next   = 1'b0;
                        state_next = (idx_reg == total_dec) ? ST_TOPRD : ST_SHIFT;
                    end else if (idx_reg == total_dec) begin
                        state_next = ST_TOPRD;
                    end
                end
            end
            ST_SHIFT: begin
                // Move the entry above down by one and fetch the next one.
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = rd_data;
                if (idx_reg == total_dec) begin
                    state_next = ST_TOPRD;
                end else begin
                    idx_next  = idx_inc;
                    mem_raddr = ptr_reg[AW-1:0];
                    ptr_next  = ptr_inc;
                end
            end
            ST_TOPRD: begin
                res_next = '0;
                if (total_reg == '0) begin
                    res_next.action = ACT_STOP;
                    state_next      = ST_EMIT;
                end else begin
                    mem_raddr  = total_dec[AW-1:0];
                    state_next = ST_TOPRES;
                end
            end
            ST_TOPRES: begin
                alu_a              = rd_data;
                res_next           = '0;
                res_next.action    = ACT_TRANSPOSE;
                res_next.transpose = alu_diff;
                state_next         = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_load     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result as loaded into the output register, with the count after the event.
    always_comb begin
        m_load_data            = res_reg;
        m_load_data.held_count = COUNT_W'(total_reg);
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            vld_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            vld_reg   <= vld_next;
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            root_reg <= ROOT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PATTERN_MODE: mode_reg <= cfg_wdata[0];
                CFG_ROOT_NOTE:    root_reg <= cfg_wdata;
                default:          mode_reg <= mode_reg;
            endcase
        end
    end

    // Payload registers: latched item, walk pointers, staged and output results.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg   <= s_data.op;
            note_reg <= s_data.note;
            vel_reg  <= s_data.velocity;
        end
        ptr_reg <= ptr_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
        if (m_load) begin
            m_data_reg <= m_load_data;
        end
    end

    // The stack count never passes its depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CW'(MAX_HELD))
        else $error("held note count exceeds stack depth");

    // A compaction write stays inside the held part of the stack.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> (idx_reg < total_reg))
        else $error("compaction write beyond held notes");

    // An accepted event with a result keeps the input closed next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_data.op != OP_UNUSED)) |=> !s_ready)
        else $error("input reopened before event finished");

    // A staged result that finds the output free is presented next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && (!m_valid_reg || m_ready)) |=> (m_valid && s_ready))
        else $error("staged result not presented");

endmodule

@@ rtl/core/hnts_alu.sv @@
module hnts_alu
    import hnts_pkg::*;
(
    input  logic [NOTE_W-1:0]         a,
    input  logic [NOTE_W-1:0]         b,
    output logic signed [XPOSE_W-1:0] diff,
    output logic                      eq
);

    // Shared unit: note match compare and transpose subtraction.
    assign diff = $signed({1'b0, a} - {1'b0, b});
    assign eq   = (a == b);

endmodule

@@ rtl/core/hnts_mem.sv @@
module hnts_mem
    import hnts_pkg::*;
#(
    parameter int DEPTH = HELD_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [NOTE_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [NOTE_W-1:0] rdata
);

    logic [NOTE_W-1:0] mem [DEPTH];
    logic [NOTE_W-1:0] rdata_reg;

    // Single write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, read every cycle.
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
